// ----- rtl/srpr_pkg.sv -----
// ----------------------------------------------------------------------------
// srpr_pkg
// Shared types and constants for the servo reply packet receiver.
// ----------------------------------------------------------------------------
package srpr_pkg;

    // Byte queue between the front classifier and the back executor
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // Byte kinds as tagged by the front end
    localparam logic [2:0] KIND_START      = 3'd0;
    localparam logic [2:0] KIND_HEADER     = 3'd1;
    localparam logic [2:0] KIND_DATA_FIRST = 3'd2;
    localparam logic [2:0] KIND_DATA       = 3'd3;
    localparam logic [2:0] KIND_CHECK      = 3'd4;

    localparam logic [7:0] START_FLAG_MASK = 8'h80;
    localparam logic [2:0] MIN_LENGTH      = 3'd4;

    localparam int unsigned REPLY_W = 57;
    localparam int unsigned TDATA_W = 64;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } qwr_t;

    // Last member lands in the lowest bits
    typedef struct packed {
        logic        pin_state;
        logic        in_motion;
        logic [2:0]  alarm_code;
        logic        servo_mode;
        logic        on_position;
        logic [6:0]  status_bits;
        logic [27:0] signed_value;
        logic [2:0]  packet_length;
        logic [4:0]  function_code;
        logic [6:0]  drive_id;
    } reply_t;

endpackage

// ----- rtl/srpr_front.sv -----
// ----------------------------------------------------------------------------
// srpr_front
// Tracks packet framing and tags each received byte with its role.
// ----------------------------------------------------------------------------
module srpr_front
    import srpr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    output qwr_t       qwr
);

    logic [2:0] pos_reg, pos_next;
    logic [2:0] len_reg, len_next;
    logic       more_data;

    assign more_data = ({1'b0, pos_reg} + 4'd1) < {1'b0, len_reg};

    always_comb begin
        pos_next        = pos_reg;
        len_next        = len_reg;
        qwr.push        = 1'b0;
        qwr.entry.kind  = KIND_START;
        qwr.entry.data  = s_tdata;
        if (s_tvalid && s_tready) begin
            priority if (pos_reg == 3'd0) begin
                // idle: bytes with the flag bit set are dropped here
                if ((s_tdata & START_FLAG_MASK) == 8'h00) begin
                    qwr.push = 1'b1;
                    pos_next = 3'd1;
                end
            end else if (pos_reg == 3'd1) begin
                qwr.push       = 1'b1;
                qwr.entry.kind = KIND_HEADER;
                len_next       = MIN_LENGTH + {1'b0, s_tdata[6:5]};
                pos_next       = 3'd2;
            end else if (more_data) begin
                qwr.push       = 1'b1;
                qwr.entry.kind = (pos_reg == 3'd2) ? KIND_DATA_FIRST : KIND_DATA;
                pos_next       = pos_reg + 3'd1;
            end else begin
                qwr.push       = 1'b1;
                qwr.entry.kind = KIND_CHECK;
                pos_next       = 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 3'd0;
            len_reg <= 3'd0;
        end else begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

endmodule

// ----- rtl/srpr_queue.sv -----
// ----------------------------------------------------------------------------
// srpr_queue
// Small FIFO of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module srpr_queue
    import srpr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  qwr_t   qwr,
    output logic   full,
    output logic   q_valid,
    output entry_t q_entry,
    input  logic   pop
);

    entry_t           mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   count_reg, count_next;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (qwr.push && !pop) count_next = count_reg + QCW'(1);
        else if (!qwr.push && pop) count_next = count_reg - QCW'(1);
    end

    always_ff @(posedge aclk) begin
        if (qwr.push) mem[wr_ptr_reg] <= qwr.entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (qwr.push) wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)      rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        qwr.push |-> !full)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCW'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QAW-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/srpr_back.sv -----
// ----------------------------------------------------------------------------
// srpr_back
// Consumes tagged bytes: checksum, value assembly and result register.
// ----------------------------------------------------------------------------
module srpr_back
    import srpr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_valid,
    input  entry_t q_entry,
    output logic   pop,
    output logic   m_tvalid,
    input  logic   m_tready,
    output reply_t reply
);

    logic [6:0]  drive_reg;
    logic [4:0]  func_reg;
    logic [2:0]  len_reg;
    logic [7:0]  sum_reg;
    logic [27:0] acc_reg;
    logic [6:0]  first_reg;
    reply_t      reply_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_free, is_check, sum_ok, emit;
    logic [6:0]  low7;

    assign low7     = q_entry.data[6:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_check = (q_entry.kind == KIND_CHECK);
    assign pop      = q_valid && (!is_check || out_free);
    assign sum_ok   = (q_entry.data == (START_FLAG_MASK | sum_reg));
    assign emit     = pop && is_check && sum_ok;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            unique case (q_entry.kind)
                KIND_START: begin
                    drive_reg <= low7;
                    sum_reg   <= q_entry.data;
                end
                KIND_HEADER: begin
                    func_reg <= q_entry.data[4:0];
                    len_reg  <= MIN_LENGTH + {1'b0, q_entry.data[6:5]};
                    sum_reg  <= sum_reg + q_entry.data;
                end
                KIND_DATA_FIRST: begin
                    first_reg <= low7;
                    acc_reg   <= {{21{low7[6]}}, low7};
                    sum_reg   <= sum_reg + q_entry.data;
                end
                KIND_DATA: begin
                    acc_reg <= {acc_reg[20:0], low7};
                    sum_reg <= sum_reg + q_entry.data;
                end
                default: ;
            endcase
        end
        if (emit) begin
            reply_reg.drive_id      <= drive_reg;
            reply_reg.function_code <= func_reg;
            reply_reg.packet_length <= len_reg;
            reply_reg.signed_value  <= acc_reg;
            reply_reg.status_bits   <= first_reg;
            reply_reg.on_position   <= first_reg[0];
            reply_reg.servo_mode    <= first_reg[1];
            reply_reg.alarm_code    <= first_reg[4:2];
            reply_reg.in_motion     <= first_reg[5];
            reply_reg.pin_state     <= first_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else          m_tvalid_reg <= m_tvalid_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign reply    = reply_reg;

    a_new_result_from_check: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(emit))
        else $error("result raised without a good checksum byte");

    a_check_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && is_check && m_tvalid_reg && !m_tready) |-> !pop)
        else $error("checksum byte consumed while result blocked");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> len_reg >= MIN_LENGTH)
        else $error("result with packet length below minimum");

endmodule

// ----- rtl/servo_reply_packet_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// servo_reply_packet_receiver_unit
// Deframes servo reply packets from a serial byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per clock. A front end tracks framing and tags each byte
// (start, header, data, checksum); a four-entry byte queue feeds a back end
// that keeps the running sum and the 28-bit value and loads the output
// register. With the queue drained, the checksum byte is written into the
// queue and popped by the back end, which registers m_tvalid high.
// Bytes seen while idle with bit 7 set are discarded; packets with a bad
// checksum are dropped without a result. Input stalls only when the queue
// fills, which happens only while a finished result waits on m_tready.
module servo_reply_packet_receiver_unit
    import srpr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [6:0] drive_id, [11:7] function_code, [14:12] packet_length,
    // [42:15] signed_value, [49:43] status_bits, [50] on_position,
    // [51] servo_mode, [54:52] alarm_code, [55] in_motion, [56] pin_state
    output logic [TDATA_W-1:0]   m_tdata
);

    qwr_t   qwr;
    logic   q_full, q_valid, q_pop;
    entry_t q_entry;
    reply_t reply;

    assign s_tready = !q_full;

    srpr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qwr      (qwr)
    );

    srpr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qwr     (qwr),
        .full    (q_full),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (q_pop)
    );

    srpr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .reply    (reply)
    );

    assign m_tdata = {{(TDATA_W-REPLY_W){1'b0}}, reply};

endmodule
